@@ design/reader_change_status_table_unit_assert.svh @@
// Assertion macros for the reader change status table unit.
// Used by the top level only; no other dependencies.
`ifndef READER_CHANGE_STATUS_TABLE_UNIT_ASSERT_SVH
`define READER_CHANGE_STATUS_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RCST_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define RCST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RCST_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RCST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/rcst_pkg.sv @@
// Package for the reader change status table unit: types, codes and sizes.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
package rcst_pkg;
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam logic [3:0] ACT_ADD = 4'd0;
	localparam logic [3:0] ACT_ACK = 4'd1;
	localparam logic [3:0] ACT_REQUEST = 4'd2;
	localparam logic [3:0] ACT_REQ_UNDERWAY = 4'd3;
	localparam logic [3:0] ACT_UNSENT_UNDERWAY = 4'd4;
	localparam logic [3:0] ACT_TO_UNACKED = 4'd5;
	localparam logic [3:0] ACT_TO_ACKED = 4'd6;
	localparam logic [3:0] ACT_INVALIDATE = 4'd7;
	localparam logic [3:0] ACT_QUERY = 4'd8;
	localparam logic [3:0] ACT_LOOKUP = 4'd9;

	localparam logic [2:0] ST_UNSENT = 3'd0;
	localparam logic [2:0] ST_REQUESTED = 3'd1;
	localparam logic [2:0] ST_UNDERWAY = 3'd2;
	localparam logic [2:0] ST_UNACKED = 3'd3;
	localparam logic [2:0] ST_ACKED = 3'd4;

	typedef struct packed {
		logic [3:0] action;
		logic [63:0] seq;
		logic [2:0] init_status;
	} rcst_in_t;

	typedef struct packed {
		logic [63:0] out_seq;
		logic seq_present;
		logic [2:0] out_status;
		logic entry_ok;
		logic flag;
		logic requests_empty;
		logic error;
		logic last;
	} rcst_out_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;         // capture the input transaction
		logic rd;           // read entry at scan position (or head when rd_head)
		logic rd_head;
		logic scan_clr;     // reset scan position to 0
		logic scan_inc;
		logic do_add;       // append the operand
		logic drop;         // drop head
		logic wr_status;    // write new status at read slot
		logic [2:0] new_status;
		logic wr_invalid;   // clear valid mark at read slot
		logic clr_noreq;
		logic emit;
		logic [2:0] emit_kind;
		logic emit_last;
		logic set_found;
		logic set_any;
		logic set_err;
		logic clr_flags;
	} rcst_cmd_t;

	localparam logic [2:0] EM_PLAIN = 3'd0;
	localparam logic [2:0] EM_ENTRY = 3'd1;
	localparam logic [2:0] EM_ADD = 3'd2;
	localparam logic [2:0] EM_FLAGS = 3'd3;

	// Datapath to controller status.
	typedef struct packed {
		logic [3:0] action;
		logic [2:0] init_status;
		logic scan_done;    // scan position reached entry count
		logic empty;
		logic full;
		logic tail_ge;      // tail seq >= operand
		logic rd_hit;       // read seq equals operand
		logic rd_lt;        // read seq below operand
		logic rd_valid;
		logic [2:0] rd_status;
		logic head_lt;      // head seq below operand
		logic found;
	} rcst_stat_t;
endpackage

@@ design/reader_change_status_table_unit.sv @@
// Top level of the reader change status table; depends on rcst_pkg and the assert header.
// An add result passes the operand register, the dispatch state, the datapath result register and
// the output register; walks read and evaluate each entry, then each dropped head entry, in turn.
// Throughput: one transaction at a time, set by the table walk through the one read port.
// Each result shows for one cycle with result_valid; the receiver cannot stall.
// Reset (arst_n, asynchronous): table empty, request flag set; entry memories unset.
`timescale 1ns / 1ps
`default_nettype none
`include "reader_change_status_table_unit_assert.svh"
module reader_change_status_table_unit
	import rcst_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire rcst_in_t in_item,
	output logic result_valid,
	output rcst_out_t result
);
	rcst_cmd_t cmd;
	rcst_stat_t stat;
	rcst_out_t dp_res;
	logic emit_q;
	logic valid_q;
	logic pend_q;
	rcst_out_t pend_res_q;
	rcst_out_t out_q;
	rcst_out_t fin_c;

	rcst_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.stat(stat), .cmd(cmd)
	);

	rcst_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_item),
		.cmd(cmd), .stat(stat), .result(dp_res)
	);

	always_comb begin
		fin_c = pend_res_q;
		fin_c.last = 1'b1;
	end

	// Moved entries are held in a register until the next one comes, so the final one can carry last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= 1'b0;
			valid_q <= 1'b0;
			pend_q <= 1'b0;
			pend_res_q <= '0;
			out_q <= '0;
		end else begin
			emit_q <= cmd.emit;
			valid_q <= emit_q && (pend_q || dp_res.last);
			if (emit_q) begin
				pend_q <= !dp_res.last;
				if (!dp_res.last)
					pend_res_q <= dp_res;
				if (pend_q)
					out_q <= dp_res.last ? fin_c : pend_res_q;
				else
					out_q <= dp_res;
			end
		end
	end

	assign result = out_q;
	assign result_valid = valid_q;

	`RCST_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`RCST_ASSERT_IMPL(a_no_add_when_full, clk, arst_n, cmd.do_add, !stat.full)
	`RCST_ASSERT_IMPL(a_no_drop_empty, clk, arst_n, cmd.drop, !stat.empty)
endmodule
`default_nettype wire

@@ design/rcst_datapath.sv @@
// Datapath: entry memories, ring pointers, scan counter and result register.
// Depends on rcst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rcst_datapath
	import rcst_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire rcst_in_t in_item,
	input wire rcst_cmd_t cmd,
	output rcst_stat_t stat,
	output rcst_out_t result
);
	logic [63:0] seq_mem [TABLE_DEPTH];
	logic [2:0] st_mem [TABLE_DEPTH];
	logic val_mem [TABLE_DEPTH];

	rcst_in_t op_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_q;
	logic noreq_q;
	logic [63:0] tail_seq_q;
	logic [63:0] rd_seq_q;
	logic [2:0] rd_st_q;
	logic rd_val_q;
	logic [IDX_W-1:0] rd_slot_q;
	logic found_q, any_q, err_q;
	rcst_out_t res_q;
	rcst_out_t res_d;

	logic [IDX_W-1:0] slot_c, tail_slot_c;
	logic [CNT_W:0] sum_c;

	always_comb begin
		sum_c = {1'b0, head_q} + (cmd.rd_head ? '0 : {1'b0, scan_q});
		slot_c = sum_c[IDX_W-1:0];
		tail_slot_c = IDX_W'(({1'b0, head_q} + {1'b0, count_q}) % TABLE_DEPTH);
		if (TABLE_DEPTH > 1 && sum_c >= (CNT_W+1)'(TABLE_DEPTH))
			slot_c = IDX_W'(sum_c - (CNT_W+1)'(TABLE_DEPTH));
	end

	always_ff @(posedge clk) begin
		if (cmd.do_add) begin
			seq_mem[tail_slot_c] <= op_q.seq;
			st_mem[tail_slot_c] <= op_q.init_status;
			val_mem[tail_slot_c] <= 1'b1;
			tail_seq_q <= op_q.seq;
		end
		if (cmd.wr_status)
			st_mem[rd_slot_q] <= cmd.new_status;
		if (cmd.wr_invalid)
			val_mem[rd_slot_q] <= 1'b0;
		if (cmd.rd) begin
			rd_seq_q <= seq_mem[slot_c];
			rd_st_q <= st_mem[slot_c];
			rd_val_q <= val_mem[slot_c];
			rd_slot_q <= slot_c;
		end
		if (cmd.wr_status)
			rd_st_q <= cmd.new_status;
		if (cmd.load)
			op_q <= in_item;
	end

	always_comb begin
		res_d = '0;
		if (cmd.emit) begin
			res_d.last = cmd.emit_last;
			res_d.requests_empty = noreq_q && !cmd.clr_noreq;
			case (cmd.emit_kind)
				EM_ENTRY: begin
					res_d.out_seq = rd_seq_q;
					res_d.seq_present = 1'b1;
					res_d.out_status = cmd.wr_status ? cmd.new_status : rd_st_q;
					res_d.entry_ok = rd_val_q;
				end
				EM_ADD: begin
					res_d.out_seq = op_q.seq;
					res_d.seq_present = 1'b1;
					res_d.out_status = op_q.init_status;
					res_d.entry_ok = 1'b1;
				end
				EM_FLAGS: begin
					res_d.flag = any_q;
					res_d.error = err_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
			scan_q <= '0;
			noreq_q <= 1'b1;
			found_q <= 1'b0;
			any_q <= 1'b0;
			err_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (cmd.do_add)
				count_q <= count_q + 1'b1;
			if (cmd.drop) begin
				head_q <= IDX_W'(({1'b0, head_q} + 1'b1) % TABLE_DEPTH);
				count_q <= count_q - 1'b1;
			end
			if (cmd.scan_clr)
				scan_q <= '0;
			else if (cmd.scan_inc)
				scan_q <= scan_q + 1'b1;
			if (cmd.clr_noreq)
				noreq_q <= 1'b0;
			found_q <= cmd.set_found || (found_q && !cmd.clr_flags);
			any_q <= cmd.set_any || (any_q && !cmd.clr_flags);
			err_q <= cmd.set_err || (err_q && !cmd.clr_flags);
			res_q <= res_d;
		end
	end

	always_comb begin
		stat.action = op_q.action;
		stat.init_status = op_q.init_status;
		stat.scan_done = scan_q >= count_q;
		stat.empty = count_q == '0;
		stat.full = count_q >= CNT_W'(TABLE_DEPTH);
		stat.tail_ge = tail_seq_q >= op_q.seq;
		stat.rd_hit = rd_seq_q == op_q.seq;
		stat.rd_lt = rd_seq_q < op_q.seq;
		stat.rd_valid = rd_val_q;
		stat.rd_status = rd_st_q;
		stat.head_lt = rd_seq_q < op_q.seq;
		stat.found = found_q;
	end

	assign result = res_q;
endmodule
`default_nettype wire

@@ design/rcst_ctrl.sv @@
// Controller state machine sequencing each action, including the table walks of the walking actions.
// Depends on rcst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rcst_ctrl
	import rcst_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire rcst_stat_t stat,
	output rcst_cmd_t cmd
);
	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_DISP = 8'b0000_0010,
		S_READ = 8'b0000_0100,
		S_EVAL = 8'b0000_1000,
		S_HREAD = 8'b0001_0000,
		S_HEVAL = 8'b0010_0000,
		S_DONE = 8'b0100_0000,
		S_WAIT = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic inv_q, inv_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			inv_q <= 1'b0;
		end else begin
			state_q <= state_d;
			inv_q <= inv_d;
		end
	end

	assign busy = state_q != S_IDLE;

	logic is_move, is_mark;
	logic [2:0] from_st;
	always_comb begin
		is_move = stat.action == ACT_REQ_UNDERWAY || stat.action == ACT_UNSENT_UNDERWAY;
		is_mark = stat.action == ACT_TO_UNACKED || stat.action == ACT_TO_ACKED;
		from_st = stat.action == ACT_REQ_UNDERWAY ? ST_REQUESTED : ST_UNSENT;
	end

	always_comb begin
		state_d = state_q;
		inv_d = inv_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				cmd.scan_clr = 1'b1;
				cmd.clr_flags = 1'b1;
				inv_d = 1'b0;
				case (stat.action)
					ACT_ADD: begin
						cmd.emit = 1'b1;
						cmd.emit_last = 1'b1;
						if (stat.full || stat.init_status > ST_ACKED ||
								(!stat.empty && stat.tail_ge)) begin
							cmd.emit_kind = EM_FLAGS;
							cmd.set_err = 1'b1;
							state_d = S_WAIT;
							cmd.emit = 1'b0;
						end else begin
							cmd.do_add = 1'b1;
							cmd.emit_kind = EM_ADD;
							state_d = S_IDLE;
						end
					end
					ACT_ACK: state_d = S_HREAD;
					ACT_REQUEST, ACT_REQ_UNDERWAY, ACT_UNSENT_UNDERWAY, ACT_TO_UNACKED,
					ACT_TO_ACKED, ACT_INVALIDATE, ACT_QUERY, ACT_LOOKUP:
						state_d = S_READ;
					default: begin
						cmd.emit = 1'b1;
						cmd.emit_last = 1'b1;
						cmd.emit_kind = EM_PLAIN;
						state_d = S_IDLE;
					end
				endcase
			end
			S_READ: begin
				if (stat.scan_done || stat.found) begin
					state_d = S_DONE;
				end else begin
					cmd.rd = 1'b1;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.scan_inc = 1'b1;
				state_d = S_READ;
				case (stat.action)
					ACT_REQUEST, ACT_LOOKUP: begin
						if (stat.rd_hit) begin
							cmd.set_found = 1'b1;
							cmd.emit = 1'b1;
							cmd.emit_last = 1'b1;
							cmd.emit_kind = EM_ENTRY;
							if (stat.action == ACT_REQUEST) begin
								cmd.wr_status = 1'b1;
								cmd.new_status = ST_REQUESTED;
								cmd.clr_noreq = 1'b1;
							end
							state_d = S_IDLE;
						end
					end
					ACT_INVALIDATE: begin
						if (stat.rd_hit) begin
							cmd.set_found = 1'b1;
							cmd.wr_invalid = 1'b1;
							inv_d = 1'b1;
						end
					end
					ACT_QUERY: begin
						if (stat.rd_status == ST_UNACKED)
							cmd.set_any = 1'b1;
					end
					default: begin
						if (is_move && stat.rd_status == from_st) begin
							cmd.wr_status = 1'b1;
							cmd.new_status = ST_UNDERWAY;
							cmd.emit = 1'b1;
							cmd.emit_kind = EM_ENTRY;
						end else if (is_mark && stat.rd_status == ST_UNDERWAY) begin
							cmd.wr_status = 1'b1;
							cmd.new_status = stat.action == ACT_TO_UNACKED ?
								ST_UNACKED : ST_ACKED;
						end
					end
				endcase
			end
			S_DONE: begin
				state_d = S_IDLE;
				case (stat.action)
					ACT_REQUEST, ACT_LOOKUP, ACT_QUERY: begin
						cmd.emit = 1'b1;
						cmd.emit_last = 1'b1;
						cmd.emit_kind = EM_FLAGS;
					end
					ACT_REQ_UNDERWAY, ACT_UNSENT_UNDERWAY: begin
						// The closing strobe marks a held moved entry as the last one.
						cmd.emit = 1'b1;
						cmd.emit_last = 1'b1;
						cmd.emit_kind = EM_PLAIN;
					end
					ACT_INVALIDATE: begin
						cmd.rd = 1'b1;
						cmd.rd_head = 1'b1;
						state_d = S_HEVAL;
					end
					ACT_TO_ACKED: begin
						state_d = S_HREAD;
					end
					default: begin
						cmd.emit = 1'b1;
						cmd.emit_last = 1'b1;
						cmd.emit_kind = EM_PLAIN;
					end
				endcase
			end
			S_HREAD: begin
				if (stat.empty) begin
					cmd.emit = 1'b1;
					cmd.emit_last = 1'b1;
					cmd.emit_kind = EM_FLAGS;
					if (stat.action == ACT_ACK)
						cmd.set_any = 1'b1;
					state_d = S_WAIT;
					cmd.emit = 1'b0;
				end else begin
					cmd.rd = 1'b1;
					cmd.rd_head = 1'b1;
					state_d = S_HEVAL;
				end
			end
			S_HEVAL: begin
				case (stat.action)
					ACT_ACK: begin
						if (stat.head_lt) begin
							cmd.drop = 1'b1;
							state_d = S_HREAD;
						end else begin
							state_d = S_WAIT;
						end
					end
					ACT_INVALIDATE: begin
						if (stat.empty) begin
							state_d = S_WAIT;
						end else if (!inv_q) begin
							if (stat.head_lt)
								cmd.set_err = 1'b1;
							state_d = S_WAIT;
						end else if (stat.head_lt) begin
							state_d = S_WAIT;
						end else if (!stat.rd_valid || stat.rd_status == ST_ACKED) begin
							cmd.drop = 1'b1;
							state_d = S_HREAD;
						end else begin
							state_d = S_WAIT;
						end
					end
					default: begin
						if (!stat.rd_valid || stat.rd_status == ST_ACKED) begin
							cmd.drop = 1'b1;
							state_d = S_HREAD;
						end else begin
							state_d = S_WAIT;
						end
					end
				endcase
			end
			S_WAIT: begin
				cmd.emit = 1'b1;
				cmd.emit_last = 1'b1;
				cmd.emit_kind = stat.action == ACT_TO_ACKED ? EM_PLAIN : EM_FLAGS;
				if (stat.action == ACT_ACK && stat.empty)
					cmd.set_any = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire
